>>> rtl/core/tcis_pkg.sv
// Shared types and codes of the small 16-bit processor core.
package tcis_pkg;

  // Payload widths of the two stream channels.
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // Item operation codes carried in in_tuser.
  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_PROG = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PWRITE,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC,
    ST_MEMRD,
    ST_RDREG,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic prog_write;
    logic fetch;
    logic decode;
    logic exec;
    logic mem_load;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] in_op;
    logic       halted;
    logic       is_load;
    logic       clear_last;
  } sts_t;

endpackage

>>> rtl/core/tcis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcis_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/tcis_ctrl.sv
// Sequencer of the processor core: state machine and output handshake.
module tcis_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tcis_pkg::sts_t sts,
  output tcis_pkg::cmd_t cmd
);

  import tcis_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (sts.in_op)
            OP_EXEC: state_nxt = sts.halted ? ST_RDREG : ST_FETCH;
            OP_PROG: state_nxt = ST_PWRITE;
            default: state_nxt = ST_RDREG;
          endcase
        end
      end
      ST_PWRITE: state_nxt = ST_RDREG;
      ST_FETCH:  state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = sts.is_load ? ST_MEMRD : ST_RDREG;
      ST_MEMRD:  state_nxt = ST_RDREG;
      ST_RDREG:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    cmd            = '0;
    cmd.accept     = (state_r == ST_IDLE) && in_tvalid;
    cmd.clear_step = (state_r == ST_CLEAR);
    cmd.prog_write = (state_r == ST_PWRITE);
    cmd.fetch      = (state_r == ST_FETCH);
    cmd.decode     = (state_r == ST_DECODE);
    cmd.exec       = (state_r == ST_EXEC);
    cmd.mem_load   = (state_r == ST_MEMRD);
    cmd.out_load   = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // One item at a time: an accepted item closes the input until it is done.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened while an item is at work");

  // Stores are written by one command at a time.
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.prog_write, cmd.exec, cmd.mem_load, cmd.clear_step}))
    else $error("overlapping store write commands");

endmodule

>>> rtl/core/tcis_dpath.sv
// Datapath of the processor core: stores, registers, ALU and result register.
module tcis_dpath #(
  parameter int PROG_WORDS  = 1024,
  parameter int DATA_BLOCKS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcis_pkg::cmd_t                     cmd,
  output tcis_pkg::sts_t                     sts,
  input  logic [tcis_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [tcis_pkg::IN_USER_W-1:0]    in_tuser,
  output logic [tcis_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import tcis_pkg::*;

  localparam int PAW    = $clog2(PROG_WORDS);
  localparam int DDEPTH = DATA_BLOCKS * 256;
  localparam int DAW    = $clog2(DDEPTH);

  localparam logic [3:0] ALU_MOV = 4'd0;
  localparam logic [3:0] ALU_OR  = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_XOR = 4'd3;
  localparam logic [3:0] ALU_ADD = 4'd4;
  localparam logic [3:0] ALU_SUB = 4'd5;
  localparam logic [3:0] ALU_SHL = 4'd6;
  localparam logic [3:0] ALU_SHR = 4'd7;
  localparam logic [3:0] ALU_ASR = 4'd8;
  localparam logic [3:0] ALU_NOT = 4'd9;
  localparam logic [3:0] ALU_NEG = 4'd10;

  typedef enum logic [2:0] {
    CL_HALT, CL_LDI, CL_ALU, CL_LOAD, CL_STORE, CL_JUMP, CL_BRANCH, CL_SKIP
  } iclass_t;

  // Latched item fields.
  logic [9:0]  pa_r, pa_nxt;
  logic [15:0] pw_r, pw_nxt;
  logic [3:0]  ri_r, ri_nxt;

  // Architectural state.
  logic [15:0] pc_r, pc_nxt;
  logic        carry_r, carry_nxt;
  logic        zero_r, zero_nxt;
  logic        sign_r, sign_nxt;
  logic        over_r, over_nxt;
  logic        halt_r, halt_nxt;
  logic        fault_r, fault_nxt;

  // Sequencing helpers.
  logic [15:0]           instr_r, instr_nxt;
  logic                  fetch_ok_r, fetch_ok_nxt;
  logic                  load_ok_r, load_ok_nxt;
  logic [DAW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;

  // Store ports.
  logic [15:0]    prog_q, rf_a_q, rf_b_q, data_q;
  logic           prog_we;
  logic [15:0]    pa_ext;
  logic [3:0]     rf_a_addr;
  logic           rf_we;
  logic [3:0]     rf_waddr;
  logic [15:0]    rf_wdata;
  logic           data_we;
  logic [DAW-1:0] data_waddr;
  logic [15:0]    data_wdata;

  // Execute stage signals.
  iclass_t     cls;
  logic [15:0] a, b, pc_inc;
  logic [16:0] res;
  logic        blk_ok, sh_big, cond;
  logic [3:0]  flag_vec;

  assign pa_ext  = {6'd0, pa_r};
  assign prog_we = cmd.prog_write && (17'(pa_r) < 17'(PROG_WORDS));

  tcis_ram #(.WIDTH(16), .DEPTH(PROG_WORDS)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (pa_ext[PAW-1:0]),
    .wdata (pw_r),
    .raddr (pc_r[PAW-1:0]),
    .rdata (prog_q)
  );

  // Two register file copies, written alike, give two reads per cycle.
  assign rf_a_addr = cmd.decode ? prog_q[7:4] : ri_r;

  tcis_ram #(.WIDTH(16), .DEPTH(16)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_a_addr),
    .rdata (rf_a_q)
  );

  tcis_ram #(.WIDTH(16), .DEPTH(16)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (prog_q[3:0]),
    .rdata (rf_b_q)
  );

  tcis_ram #(.WIDTH(16), .DEPTH(DDEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (rf_b_q[DAW-1:0]),
    .rdata (data_q)
  );

  assign a      = rf_a_q;
  assign b      = rf_b_q;
  assign pc_inc = pc_r + 16'd1;
  assign blk_ok = {1'b0, b[15:8]} < 9'(DATA_BLOCKS);
  assign sh_big = |b[15:4];
  assign flag_vec = {over_r, sign_r, zero_r, carry_r};
  assign cond   = flag_vec[instr_r[6:5]];

  always_comb begin
    if (instr_r[15:12] == 4'h0) begin
      cls = CL_HALT;
    end else if (instr_r[15:14] == 2'b00 && instr_r[12]) begin
      cls = CL_LDI;
    end else if (instr_r[15:14] == 2'b01) begin
      cls = CL_ALU;
    end else if (instr_r[15:13] == 3'b100) begin
      cls = CL_LOAD;
    end else if (instr_r[15:13] == 3'b101) begin
      cls = CL_STORE;
    end else if (instr_r[15:13] == 3'b110) begin
      cls = CL_JUMP;
    end else if (instr_r[15:12] == 4'hf) begin
      cls = CL_BRANCH;
    end else begin
      cls = CL_SKIP;
    end
  end

  always_comb begin
    case (instr_r[11:8])
      ALU_MOV: res = {1'b0, b};
      ALU_OR:  res = {1'b0, a | b};
      ALU_AND: res = {1'b0, a & b};
      ALU_XOR: res = {1'b0, a ^ b};
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      ALU_SHL: res = sh_big ? 17'd0 : {1'b0, a << b[3:0]};
      ALU_SHR: res = sh_big ? 17'd0 : {1'b0, a >> b[3:0]};
      ALU_ASR: res = sh_big ? {1'b0, {16{a[15]}}}
                            : {1'b0, 16'($signed(a) >>> b[3:0])};
      ALU_NOT: res = {1'b1, ~b};
      ALU_NEG: res = {1'b0, 16'd0 - b};
      default: res = {1'b0, a};
    endcase
  end

  always_comb begin
    pa_nxt       = pa_r;
    pw_nxt       = pw_r;
    ri_nxt       = ri_r;
    pc_nxt       = pc_r;
    carry_nxt    = carry_r;
    zero_nxt     = zero_r;
    sign_nxt     = sign_r;
    over_nxt     = over_r;
    halt_nxt     = halt_r;
    fault_nxt    = fault_r;
    instr_nxt    = instr_r;
    fetch_ok_nxt = fetch_ok_r;
    load_ok_nxt  = load_ok_r;
    clr_cnt_nxt  = clr_cnt_r;
    out_nxt      = out_r;
    rf_we        = 1'b0;
    rf_waddr     = instr_r[7:4];
    rf_wdata     = 16'd0;
    data_we      = 1'b0;
    data_waddr   = b[DAW-1:0];
    data_wdata   = a;

    if (cmd.clear_step) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      data_we     = 1'b1;
      data_waddr  = clr_cnt_r;
      data_wdata  = 16'd0;
      rf_we       = (clr_cnt_r[DAW-1:4] == '0);
      rf_waddr    = clr_cnt_r[3:0];
    end

    if (cmd.accept) begin
      pa_nxt = in_tdata[9:0];
      pw_nxt = in_tdata[25:10];
      ri_nxt = in_tdata[29:26];
    end

    if (cmd.fetch) begin
      fetch_ok_nxt = 17'(pc_r) < 17'(PROG_WORDS);
    end

    if (cmd.decode) begin
      instr_nxt = fetch_ok_r ? prog_q : 16'd0;
    end

    if (cmd.exec) begin
      case (cls)
        CL_HALT: begin
          halt_nxt = 1'b1;
        end
        CL_LDI: begin
          rf_we    = 1'b1;
          rf_waddr = instr_r[3:0];
          rf_wdata = {8'd0, instr_r[11:4]};
          pc_nxt   = pc_inc;
        end
        CL_ALU: begin
          rf_we     = 1'b1;
          rf_wdata  = res[15:0];
          carry_nxt = res[16];
          zero_nxt  = (res[15:0] == 16'd0);
          sign_nxt  = res[15];
          over_nxt  = (!a[15] && !b[15] && res[15]) || (a[15] && b[15] && !res[15]);
          pc_nxt    = pc_inc;
        end
        CL_LOAD: begin
          load_ok_nxt = blk_ok;
          pc_nxt      = pc_inc;
        end
        CL_STORE: begin
          if (blk_ok) begin
            data_we = 1'b1;
          end else begin
            halt_nxt  = 1'b1;
            fault_nxt = 1'b1;
          end
          pc_nxt = pc_inc;
        end
        CL_JUMP: begin
          pc_nxt = b;
        end
        CL_BRANCH: begin
          pc_nxt = (cond != instr_r[4]) ? b : pc_inc;
        end
        default: begin
          pc_nxt = pc_inc;
        end
      endcase
    end

    if (cmd.mem_load) begin
      rf_we    = 1'b1;
      rf_wdata = load_ok_r ? data_q : 16'd0;
    end

    if (cmd.out_load) begin
      out_nxt = {2'b00, rf_a_q, fault_r, halt_r, over_r, sign_r, zero_r, carry_r, pc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 16'd0;
      carry_r   <= 1'b0;
      zero_r    <= 1'b0;
      sign_r    <= 1'b0;
      over_r    <= 1'b0;
      halt_r    <= 1'b0;
      fault_r   <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      pc_r      <= pc_nxt;
      carry_r   <= carry_nxt;
      zero_r    <= zero_nxt;
      sign_r    <= sign_nxt;
      over_r    <= over_nxt;
      halt_r    <= halt_nxt;
      fault_r   <= fault_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    pw_r       <= pw_nxt;
    ri_r       <= ri_nxt;
    instr_r    <= instr_nxt;
    fetch_ok_r <= fetch_ok_nxt;
    load_ok_r  <= load_ok_nxt;
    out_r      <= out_nxt;
  end

  assign out_tdata      = out_r;
  assign sts.in_op      = in_tuser;
  assign sts.halted     = halt_r;
  assign sts.is_load    = (cls == CL_LOAD);
  assign sts.clear_last = (clr_cnt_r == DAW'(DDEPTH - 1));

  // A fault is only ever raised together with halt.
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> halt_r)
    else $error("memory fault without halt");

  // Only reset leaves the halted state.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  // A store outside data memory must raise the fault.
  a_store_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cls == CL_STORE && !blk_ok) |=> fault_r)
    else $error("out-of-range store did not fault");

endmodule

>>> rtl/core/tiny_cpu_instruction_step_core.sv
// Top level of the small 16-bit processor core with stream ports.
//
//   Channel  Direction  Handshake               Payload
//   in_      slave      in_tvalid / in_tready   in_tdata[31:0], in_tuser[1:0]
//   out_     master     out_tvalid / out_tready out_tdata[39:0]
//
// Each accepted item gives exactly one result item. An execute item passes
// through program fetch, register read, execute, an optional data read for a
// load, and the register read for the report, all through registered store
// ports in turn. An execute item while halted and a register read item go
// straight to the register read for the report, and a program write item
// first writes the program store and then reads the register for the report.
// After reset the data memory and register file are cleared, one data word a
// cycle, and in_tready stays low until the clearing is done.
// A result waits in the output register while out_tready is low; the next item
// is still accepted and worked on, and only its own result waits for the
// output register to empty.
module tiny_cpu_instruction_step_core #(
  parameter int PROG_WORDS  = 1024,
  parameter int DATA_BLOCKS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0 up: prog_address[9:0], prog_word[15:0], reg_index[3:0],
  // then two zero bits.
  input  logic [tcis_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0 up: operation[1:0].
  input  logic [tcis_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0 up: pc_value[15:0], carry_flag, zero_flag, sign_flag,
  // overflow_flag, halted, memory_fault, reg_value[15:0], then two zero bits.
  output logic [tcis_pkg::OUT_DATA_W-1:0] out_tdata
);

  import tcis_pkg::*;

  // Commands travel from the sequencer to the datapath, status comes back.
  cmd_t cmd;
  sts_t sts;

  tcis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the program store, both register file copies, the
  // data store, the ALU and the result register.
  tcis_dpath #(
    .PROG_WORDS  (PROG_WORDS),
    .DATA_BLOCKS (DATA_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

>>> verif/tiny_cpu_instruction_step_core_test.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the small 16-bit processor core.
module tiny_cpu_instruction_step_core_test;
  import tcis_pkg::*;

  localparam int PROG_WORDS     = 1024;
  localparam int DATA_BLOCKS    = 16;
  localparam int DMEM_WORDS     = DATA_BLOCKS * 256;
  // The clearing pass after reset runs with in_tready low, and one long output hold-off
  // comes on top of it.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  // The fourth item operation only reports the state.
  localparam logic [1:0] OP_REPORT = 2'd3;

  // Bit positions in the status flag vector; the low four match the jump conditions.
  localparam int FLG_CARRY = 0;
  localparam int FLG_ZERO  = 1;
  localparam int FLG_SIGN  = 2;
  localparam int FLG_OVER  = 3;
  localparam int FLG_FAULT = 4;
  localparam int FLG_HALT  = 5;

  localparam logic [1:0] CC_SIGN  = 2'd2;

  localparam logic [3:0] ALU_MOV   = 4'd0;
  localparam logic [3:0] ALU_OR    = 4'd1;
  localparam logic [3:0] ALU_AND   = 4'd2;
  localparam logic [3:0] ALU_XOR   = 4'd3;
  localparam logic [3:0] ALU_ADD   = 4'd4;
  localparam logic [3:0] ALU_SUB   = 4'd5;
  localparam logic [3:0] ALU_SHL   = 4'd6;
  localparam logic [3:0] ALU_SHR   = 4'd7;
  localparam logic [3:0] ALU_SAR   = 4'd8;
  localparam logic [3:0] ALU_NOT   = 4'd9;
  localparam logic [3:0] ALU_NEG   = 4'd10;
  localparam logic [3:0] ALU_SPARE = 4'd11;

  // Top nibbles of the instruction classes, with their don't-care bits at zero.
  localparam logic [3:0] NIB_HALT     = 4'h0;
  localparam logic [3:0] NIB_LDI      = 4'h1;
  localparam logic [3:0] NIB_UNDEF_LO = 4'h2;
  localparam logic [3:0] NIB_ALU      = 4'h4;
  localparam logic [3:0] NIB_LOAD     = 4'h8;
  localparam logic [3:0] NIB_STORE    = 4'hA;
  localparam logic [3:0] NIB_JUMP     = 4'hC;
  localparam logic [3:0] NIB_UNDEF_HI = 4'hE;
  localparam logic [3:0] NIB_JCC      = 4'hF;

  typedef enum logic [2:0] {
    K_HALT, K_LDI, K_ALU, K_LOAD, K_STORE, K_JUMP, K_JCC, K_UNDEF
  } instr_kind_t;

  // One result item as it appears on out_tdata, lowest field last.
  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] reg_value;
    logic        fault;
    logic        halted;
    logic        over;
    logic        sign;
    logic        zero;
    logic        carry;
    logic [15:0] pc;
  } cpu_report_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Our own copy of the processor state.
  logic [15:0] gpr [16];
  logic [15:0] pc_q;
  logic [5:0]  flags;
  logic [15:0] imem [PROG_WORDS];
  bit          imem_written [PROG_WORDS];
  logic [15:0] dmem [DMEM_WORDS];

  cpu_report_t expected_reports [$];
  cpu_report_t want, got;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;
  int mismatch_count = 0;

  tiny_cpu_instruction_step_core #(
    .PROG_WORDS (PROG_WORDS),
    .DATA_BLOCKS(DATA_BLOCKS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic instr_kind_t decode_kind(logic [15:0] w);
    logic [3:0] n;
    n = w[15:12];
    if (n == NIB_HALT) return K_HALT;
    if ((n & 4'b1101) == NIB_LDI) return K_LDI;
    if ((n & 4'b1100) == NIB_ALU) return K_ALU;
    if ((n & 4'b1110) == NIB_LOAD) return K_LOAD;
    if ((n & 4'b1110) == NIB_STORE) return K_STORE;
    if ((n & 4'b1110) == NIB_JUMP) return K_JUMP;
    if (n == NIB_JCC) return K_JCC;
    return K_UNDEF;
  endfunction

  // Builds an instruction word; the don't-care bits are random.
  // LDI: imm = {f, x}, rd = y. ALU: fn = f, rd = x, rs = y. LOAD/STORE: rd = x, rs = y.
  // JUMP: target register y. JCC: x[2:1] condition, x[0] negate, target register y.
  function automatic logic [15:0] make_instr(instr_kind_t k, logic [3:0] f, logic [3:0] x,
                                             logic [3:0] y);
    logic [15:0] dc;
    dc = 16'($urandom);
    case (k)
      K_HALT:  return {NIB_HALT, dc[11:0]};
      K_LDI:   return {NIB_LDI | {2'b00, dc[15], 1'b0}, f, x, y};
      K_ALU:   return {NIB_ALU | {2'b00, dc[15:14]}, f, x, y};
      K_LOAD:  return {NIB_LOAD | {3'b000, dc[15]}, dc[3:0], x, y};
      K_STORE: return {NIB_STORE | {3'b000, dc[15]}, dc[3:0], x, y};
      K_JUMP:  return {NIB_JUMP | {3'b000, dc[15]}, dc[7:0], y};
      K_JCC:   return {NIB_JCC, dc[3:0], dc[15], x[2:0], y};
      default: return {dc[15] ? NIB_UNDEF_HI : NIB_UNDEF_LO, dc[11:0]};
    endcase
  endfunction

  // Loads of small immediates are frequent so that addresses and jump targets stay in range.
  function automatic logic [15:0] random_instr();
    int pick;
    instr_kind_t k;
    pick = $urandom_range(99);
    if (pick < 25)      k = K_LDI;
    else if (pick < 60) k = K_ALU;
    else if (pick < 70) k = K_LOAD;
    else if (pick < 80) k = K_STORE;
    else if (pick < 84) k = K_JUMP;
    else if (pick < 95) k = K_JCC;
    else if (pick < 98) k = K_UNDEF;
    else                k = K_HALT;
    return make_instr(k, 4'($urandom), 4'($urandom), 4'($urandom));
  endfunction

  // True when executing w now leaves the processor running at a fetchable address.
  function automatic bit keeps_running(logic [15:0] w);
    logic [15:0] nxt;
    logic [15:0] target;
    nxt = pc_q + 16'd1;
    target = gpr[w[3:0]];
    case (decode_kind(w))
      K_HALT:  return 1'b0;
      K_STORE: if (target[15:8] >= DATA_BLOCKS) return 1'b0;
      K_JUMP:  nxt = target;
      K_JCC:   if (flags[w[6:5]] != w[4]) nxt = target;
      default: ;
    endcase
    return nxt < PROG_WORDS;
  endfunction

  // The ALU result is kept wider than 16 bits so that bit 16 gives the carry.
  function automatic logic [31:0] alu_result(logic [3:0] fn, logic [15:0] a, logic [15:0] b);
    logic signed [15:0] sa;
    logic [15:0] sar;
    sa = a;
    sar = sa >>> b[3:0];
    case (fn)
      ALU_MOV: return {16'h0000, b};
      ALU_OR:  return {16'h0000, a | b};
      ALU_AND: return {16'h0000, a & b};
      ALU_XOR: return {16'h0000, a ^ b};
      ALU_ADD: return {16'h0000, a} + {16'h0000, b};
      ALU_SUB: return {16'h0000, a} - {16'h0000, b};
      ALU_SHL: return (b >= 16) ? 32'h0 : {16'h0000, a << b[3:0]};
      ALU_SHR: return (b >= 16) ? 32'h0 : {16'h0000, a >> b[3:0]};
      ALU_SAR: return (b >= 16) ? {16'h0000, {16{a[15]}}} : {16'h0000, sar};
      ALU_NOT: return ~{16'h0000, b};
      ALU_NEG: return {16'h0000, 16'h0000 - b};
      default: return {16'h0000, a};
    endcase
  endfunction

  task automatic exec_instruction();
    logic [15:0] w, nxt, a, b, ea;
    logic [31:0] r;
    if (!flags[FLG_HALT]) begin
      w = (pc_q < PROG_WORDS) ? imem[pc_q[9:0]] : 16'h0000;
      nxt = pc_q + 16'd1;
      case (decode_kind(w))
        K_HALT: flags[FLG_HALT] = 1'b1;
        K_LDI: begin
          gpr[w[3:0]] = {8'h00, w[11:4]};
          pc_q = nxt;
        end
        K_ALU: begin
          a = gpr[w[7:4]];
          b = gpr[w[3:0]];
          r = alu_result(w[11:8], a, b);
          flags[FLG_CARRY] = r[16];
          flags[FLG_ZERO]  = (r[15:0] == 16'h0000);
          flags[FLG_SIGN]  = r[15];
          // Overflow follows the addition rule whatever the operation.
          flags[FLG_OVER]  = (!a[15] && !b[15] && r[15]) || (a[15] && b[15] && !r[15]);
          gpr[w[7:4]] = r[15:0];
          pc_q = nxt;
        end
        K_LOAD: begin
          ea = gpr[w[3:0]];
          gpr[w[7:4]] = (ea[15:8] < DATA_BLOCKS) ? dmem[ea[11:0]] : 16'h0000;
          pc_q = nxt;
        end
        K_STORE: begin
          ea = gpr[w[3:0]];
          if (ea[15:8] < DATA_BLOCKS) begin
            dmem[ea[11:0]] = gpr[w[7:4]];
          end else begin
            flags[FLG_HALT]  = 1'b1;
            flags[FLG_FAULT] = 1'b1;
          end
          pc_q = nxt;
        end
        K_JUMP: pc_q = gpr[w[3:0]];
        K_JCC:  pc_q = (flags[w[6:5]] != w[4]) ? gpr[w[3:0]] : nxt;
        default: pc_q = nxt;
      endcase
    end
  endtask

  // Applies one accepted item to our copy and queues the report it must produce.
  task automatic cpu_step(input logic [1:0] op, input logic [9:0] addr,
                          input logic [15:0] word, input logic [3:0] ridx);
    cpu_report_t rep;
    if (op == OP_EXEC) begin
      exec_instruction();
    end else if (op == OP_PROG) begin
      imem[addr] = word;
      imem_written[addr] = 1'b1;
    end
    rep.pad       = 2'b00;
    rep.reg_value = gpr[ridx];
    rep.fault     = flags[FLG_FAULT];
    rep.halted    = flags[FLG_HALT];
    rep.over      = flags[FLG_OVER];
    rep.sign      = flags[FLG_SIGN];
    rep.zero      = flags[FLG_ZERO];
    rep.carry     = flags[FLG_CARRY];
    rep.pc        = pc_q;
    expected_reports.push_back(rep);
  endtask

  // Offers one item from a falling edge and returns at the falling edge after acceptance.
  task automatic send_item(input logic [1:0] op, input logic [9:0] addr,
                           input logic [15:0] word, input logic [3:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, ridx, word, addr};
    do @(posedge clk); while (!in_tready);
    cpu_step(op, addr, word, ridx);
    @(negedge clk);
  endtask

  // Writes w at the current pc (when it lies in the program store) and executes it.
  task automatic place_and_run(input logic [15:0] w, input logic [3:0] ridx);
    if (pc_q < PROG_WORDS) send_item(OP_PROG, pc_q[9:0], w, 4'($urandom));
    send_item(OP_EXEC, 10'($urandom), 16'($urandom), ridx);
  endtask

  // Executes one instruction, rewriting the word at pc when it is unwritten, would stop
  // the processor, or at random.
  task automatic run_random_instr();
    logic [15:0] w;
    int tries;
    if (pc_q < PROG_WORDS && (!imem_written[pc_q[9:0]] || !keeps_running(imem[pc_q[9:0]])
                              || $urandom_range(2) == 0)) begin
      w = random_instr();
      tries = 0;
      while (!keeps_running(w) && tries < 64) begin
        w = random_instr();
        tries++;
      end
      if (!keeps_running(w)) begin
        for (int i = 0; i < 16; i++) begin
          if (gpr[i] < PROG_WORDS) w = make_instr(K_JUMP, 4'h0, 4'h0, i[3:0]);
        end
      end
      send_item(OP_PROG, pc_q[9:0], w, 4'($urandom));
    end
    send_item(OP_EXEC, 10'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic test_reset_state();
    send_item(OP_READ, 10'h000, 16'h0000, 4'd0);
    send_item(OP_REPORT, 10'h3FF, 16'hFFFF, 4'd15);
    send_item(OP_PROG, 10'h3FF, 16'hFFFF, 4'd15);
    send_item(OP_PROG, 10'h000, 16'h0000, 4'd0);
  endtask

  task automatic test_directed_ops();
    place_and_run(make_instr(K_LDI, 4'hF, 4'hF, 4'd1), 4'd1);        // r1 = 0x00FF
    place_and_run(make_instr(K_LDI, 4'h1, 4'h0, 4'd2), 4'd2);        // r2 = 0x0010
    place_and_run(make_instr(K_ALU, ALU_SUB, 4'd0, 4'd1), 4'd0);     // borrow sets carry
    place_and_run(make_instr(K_ALU, ALU_SAR, 4'd0, 4'd2), 4'd0);     // negative, count 16
    place_and_run(make_instr(K_ALU, ALU_NOT, 4'd4, 4'd1), 4'd4);     // carry from NOT
    place_and_run(make_instr(K_ALU, ALU_NEG, 4'd5, 4'd1), 4'd5);
    place_and_run(make_instr(K_ALU, ALU_SPARE, 4'd1, 4'd1), 4'd1);   // spare op keeps A
    place_and_run(make_instr(K_UNDEF, 4'h0, 4'h0, 4'h0), 4'd15);
    place_and_run(make_instr(K_STORE, 4'h0, 4'd1, 4'd2), 4'd1);
    place_and_run(make_instr(K_LOAD, 4'h0, 4'd6, 4'd2), 4'd6);
    place_and_run(make_instr(K_LOAD, 4'h0, 4'd7, 4'd0), 4'd7);       // beyond data memory
    place_and_run(make_instr(K_JCC, 4'h0, {1'b0, CC_SIGN, 1'b1}, 4'd2), 4'd2);
  endtask

  task automatic test_random_program(input int steps);
    int pick;
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 55)      run_random_instr();
      else if (pick < 72) send_item(OP_PROG, 10'($urandom), 16'($urandom), 4'($urandom));
      else if (pick < 95) send_item(OP_READ, 10'($urandom), 16'($urandom), 4'($urandom));
      else                send_item(OP_REPORT, 10'($urandom), 16'($urandom), 4'($urandom));
    end
  endtask

  // The receiver holds off long enough for the core to fill up and drop in_tready.
  task automatic test_output_hold_off();
    stall_request = 300;
    test_random_program(40);
  endtask

  // Stops the processor in one of three ways, then checks that executes do nothing
  // while program writes and register reads still work.
  task automatic test_halt_and_fault();
    if (!flags[FLG_HALT] && pc_q > 1000) begin
      for (int i = 0; i < 16; i++) begin
        if (gpr[i] < 1000 && pc_q > 1000) place_and_run(make_instr(K_JUMP, 4'h0, 4'h0,
                                                                   i[3:0]), i[3:0]);
      end
    end
    case ($urandom_range(2))
      0: begin
        place_and_run(make_instr(K_LDI, 4'h1, 4'h0, 4'd14), 4'd14);
        place_and_run(make_instr(K_LDI, 4'h0, 4'h8, 4'd13), 4'd13);
        place_and_run(make_instr(K_ALU, ALU_SHL, 4'd14, 4'd13), 4'd14);  // r14 = 0x1000
        place_and_run(make_instr(K_STORE, 4'h0, 4'd0, 4'd14), 4'd0);     // block past the end
      end
      1: place_and_run(make_instr(K_HALT, 4'h0, 4'h0, 4'h0), 4'd0);
      default: begin
        place_and_run(make_instr(K_LDI, 4'h1, 4'h0, 4'd14), 4'd14);
        place_and_run(make_instr(K_LDI, 4'h0, 4'h8, 4'd13), 4'd13);
        place_and_run(make_instr(K_ALU, ALU_SHL, 4'd14, 4'd13), 4'd14);
        place_and_run(make_instr(K_JUMP, 4'h0, 4'h0, 4'd14), 4'd14);
        place_and_run(random_instr(), 4'd14);                           // fetch past the store
      end
    endcase
    repeat (3) place_and_run(random_instr(), 4'($urandom));
    send_item(OP_PROG, 10'($urandom), 16'($urandom), 4'($urandom));
    for (int i = 0; i < 16; i++) send_item(OP_READ, 10'($urandom), 16'($urandom), i[3:0]);
    send_item(OP_REPORT, 10'($urandom), 16'($urandom), 4'($urandom));
  endtask

  // Receiver: random ready, or a counted hold-off when one has been asked for.
  always @(negedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count < 100) begin
        $display("%0d ns: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    end
  endtask

  // Each result item is compared with the oldest outstanding report.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        $display("%0d ns: result item expected none actual %h", $time, out_tdata);
      end else begin
        want = expected_reports.pop_front();
        check_field("pc_value", want.pc, got.pc);
        check_field("carry_flag", 16'(want.carry), 16'(got.carry));
        check_field("zero_flag", 16'(want.zero), 16'(got.zero));
        check_field("sign_flag", 16'(want.sign), 16'(got.sign));
        check_field("overflow_flag", 16'(want.over), 16'(got.over));
        check_field("halted", 16'(want.halted), 16'(got.halted));
        check_field("memory_fault", 16'(want.fault), 16'(got.fault));
        check_field("reg_value", want.reg_value, got.reg_value);
        check_field("padding", 16'(want.pad), 16'(got.pad));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (gpr[i]) gpr[i] = 16'h0000;
    foreach (imem_written[i]) imem_written[i] = 1'b0;
    foreach (dmem[i]) dmem[i] = 16'h0000;
    pc_q  = 16'h0000;
    flags = 6'b000000;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 75;
    test_reset_state();
    test_directed_ops();
    test_random_program(200);

    send_idle_pct = 75;
    recv_idle_pct = 15;
    test_random_program(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_program(200);
    test_output_hold_off();
    test_halt_and_fault();
    in_tvalid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tcis_pkg.sv
rtl/core/tcis_ram.sv
rtl/core/tcis_ctrl.sv
rtl/core/tcis_dpath.sv
rtl/core/tiny_cpu_instruction_step_core.sv
verif/tiny_cpu_instruction_step_core_test.sv
